>>> rtl/uigf_pkg.sv
// ----------------------------------------------------------------------------
// uigf_pkg: shared types and constants of the idle-gap frame receiver
// Buffer sizes, opcodes, payload structs and the status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package uigf_pkg;

    localparam int BUF_DEPTH  = 64;
    localparam int READ_MAX   = 32;
    localparam int ADDR_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
    localparam int READ_LIM   = (READ_MAX < BUF_DEPTH) ? READ_MAX : BUF_DEPTH;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam int TIMER_W    = 9;
    localparam int CFG_IDX_W  = 1;

    localparam logic [7:0] TICK_MS_RESET    = 8'd1;
    localparam logic [7:0] IDLE_LIMIT_RESET = 8'd30;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_POLL = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_MS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 1'd1;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_data;
    } in_item_t;

    typedef struct packed {
        logic       frame_valid;
        logic [7:0] frame_byte;
        logic       frame_last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic [7:0] tick_ms;
        logic [7:0] idle_limit_ms;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic             frame_ready;
        logic             streaming;
    } back_status_t;

endpackage

`default_nettype wire

>>> rtl/uigf_ram.sv
// ----------------------------------------------------------------------------
// uigf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module uigf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/uigf_front.sv
// ----------------------------------------------------------------------------
// uigf_front: input acceptance and command queue
// Takes input beats, drops unused opcodes and queues the rest for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module uigf_front
    import uigf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output      logic     in_ready,
    input  wire in_item_t in_data,
    output      logic     q_valid,
    input  wire logic     q_ready,
    output      cmd_t     q_cmd
);

    cmd_t               slot_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CW-1:0] count_reg, count_next;
    logic               push;
    logic               pop;

    assign in_ready = (count_reg != CMDQ_CW'(CMDQ_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = slot_reg[rd_ptr_reg];

    // opcode three has no effect: accept the beat, queue nothing
    assign push = in_valid && in_ready && (in_data.opcode != OP_NONE);
    assign pop  = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + CMDQ_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + CMDQ_AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CMDQ_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CMDQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].opcode <= in_data.opcode;
            slot_reg[wr_ptr_reg].data   <= in_data.rx_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/uigf_back.sv
// ----------------------------------------------------------------------------
// uigf_back: command execution
// Stores bytes, runs the idle timer on ticks and streams frames on polls.
// ----------------------------------------------------------------------------
`default_nettype none

module uigf_back
    import uigf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cfg_t         cfg,
    input  wire logic         q_valid,
    output      logic         q_ready,
    input  wire cmd_t         q_cmd,
    output      logic         out_valid,
    input  wire logic         out_ready,
    output      out_item_t    out_data,
    output      back_status_t status
);

    localparam logic [1:0] ST_EXEC = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_NOFR = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   seen_reg, seen_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic               ready_reg, ready_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, out_item_next;

    logic               ram_we;
    logic               ram_re;
    logic [7:0]         ram_rdata;
    logic               out_free;
    logic [CNT_W-1:0]   idx_inc;
    logic [CNT_W-1:0]   frame_len;
    logic [TIMER_W-1:0] timer_sum;
    logic [TIMER_W-1:0] limit_ext;

    assign out_free  = !out_valid_reg || out_ready;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign frame_len = (count_reg < CNT_W'(READ_LIM)) ? count_reg : CNT_W'(READ_LIM);
    assign timer_sum = timer_reg + TIMER_W'(cfg.tick_ms);
    assign limit_ext = TIMER_W'(cfg.idle_limit_ms);
    assign q_ready   = (state_reg == ST_EXEC);
    assign ram_we    = q_valid && q_ready && (q_cmd.opcode == OP_BYTE) &&
                       (count_reg < CNT_W'(BUF_DEPTH));
    assign ram_re    = (state_reg == ST_READ);

    uigf_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (q_cmd.data),
        .re    (ram_re),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        seen_next      = seen_reg;
        timer_next     = timer_reg;
        ready_next     = ready_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;

        unique case (state_reg)
            ST_EXEC:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.opcode)
                        OP_BYTE:
                        begin
                            if (ram_we)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                seen_next = '0;
                            end
                            else if (seen_reg != count_reg)
                            begin
                                seen_next  = count_reg;
                                timer_next = '0;
                            end
                            else if (timer_reg < limit_ext)
                            begin
                                timer_next = timer_sum;
                                if (timer_sum >= limit_ext)
                                begin
                                    ready_next = 1'b1;
                                end
                            end
                        end
                        OP_POLL:
                        begin
                            if (!ready_reg)
                            begin
                                state_next = ST_NOFR;
                            end
                            else
                            begin
                                ready_next = 1'b0;
                                count_next = '0;
                                idx_next   = '0;
                                len_next   = frame_len;
                                state_next = (frame_len == '0) ? ST_NOFR : ST_READ;
                            end
                        end
                        default:
                        begin
                            // no-op opcode never reaches the queue
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // hold the read data until the output register frees up
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.frame_valid = 1'b1;
                    out_item_next.frame_byte  = ram_rdata;
                    out_item_next.frame_last  = (idx_inc == len_reg);
                    idx_next                  = idx_inc;
                    state_next                = (idx_inc == len_reg) ? ST_EXEC : ST_READ;
                end
            end
            ST_NOFR:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.frame_valid = 1'b0;
                    out_item_next.frame_byte  = '0;
                    out_item_next.frame_last  = 1'b1;
                    state_next                = ST_EXEC;
                end
            end
            default:
            begin
                state_next = ST_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_EXEC;
            count_reg     <= '0;
            seen_reg      <= '0;
            timer_reg     <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            timer_reg     <= timer_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        len_reg      <= len_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid          = out_valid_reg;
    assign out_data           = out_item_reg;
    assign status.byte_count  = count_reg;
    assign status.frame_ready = ready_reg;
    assign status.streaming   = (state_reg == ST_READ) || (state_reg == ST_LOAD);

endmodule

`default_nettype wire

>>> rtl/uart_idle_gap_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// uart_idle_gap_frame_receiver_top: idle-gap UART frame receiver
// Buffers received bytes, ends a frame on line idle time, delivers on poll.
// ----------------------------------------------------------------------------
// The execution stage takes a byte or tick beat in every cycle that no poll
// holds it; a two-entry command queue in front accepts a beat in every cycle
// while it has room, so bursts of bytes and ticks go in at full clock rate. A
// poll holds the execution stage while it runs: each delivered byte takes a
// buffer RAM read, then a load into the output register, which waits while
// that register is still full; a no-frame poll passes through the no-frame
// state instead. The output register lets the next poll byte be fetched while
// the previous beat is still waiting. The buffer RAM needs no clearing
// after reset: only entries already written are read. Configuration writes
// are taken at once and should be made while no beat is in flight.
`default_nettype none

module uart_idle_gap_frame_receiver_top
    import uigf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire in_item_t             in_data,
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      out_item_t            out_data,
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data
);

    cfg_t         cfg_reg;
    logic         q_valid;
    logic         q_ready;
    cmd_t         q_cmd;
    back_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_ms       <= TICK_MS_RESET;
            cfg_reg.idle_limit_ms <= IDLE_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TICK_MS:    cfg_reg.tick_ms       <= cfg_data;
                REG_IDLE_LIMIT: cfg_reg.idle_limit_ms <= cfg_data;
                default:        ;
            endcase
        end
    end

    uigf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    uigf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .status    (status)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.byte_count <= CNT_W'(BUF_DEPTH))
        else $error("byte count beyond buffer depth");

    a_stream_empty: assert property (@(posedge clk) disable iff (!rst_n)
        status.streaming |-> (status.byte_count == '0) && !status.frame_ready)
        else $error("buffer not emptied while a frame streams out");

    a_noframe_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.frame_valid |-> out_data.frame_last &&
        (out_data.frame_byte == 8'd0))
        else $error("no-frame beat not marked last");

    a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
        status.streaming |-> !q_ready)
        else $error("command taken while a frame streams out");

endmodule

`default_nettype wire
